/* src/ble_anc_pkg.sv */
// Shared types and constants of the connection anchor scheduler.
`timescale 1ns / 1ps
`default_nettype none

package ble_anc_pkg;

  localparam int unsigned TICK_W    = 25;
  localparam int unsigned DIV_W     = 36;
  localparam int unsigned DIV_CNT_W = 6;
  localparam int unsigned CFG_W     = 25;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [19:0] PS_PER_US      = 20'd1000000;
  localparam logic [24:0] TICK_PS_RESET  = 25'd30517578;

  localparam logic [DIV_CNT_W-1:0] DIV_BITS_DRIFT = 6'd36;
  localparam logic [DIV_CNT_W-1:0] DIV_BITS_ADV   = 6'd26;
  localparam logic [DIV_CNT_W-1:0] DIV_BITS_START = 6'd25;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERVAL_TICKS,
    CFG_INTERVAL_REM_PS,
    CFG_TICK_PERIOD_PS,
    CFG_WIDEN_STEP_US,
    CFG_WIDEN_LIMIT_US,
    CFG_TIMEOUT_TICKS,
    CFG_GUARD_US,
    CFG_EXPECTED_S2A_US
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_START_WAIT,
    ST_DRIFT_ADD,
    ST_DRIFT_WAIT,
    ST_ADV_START,
    ST_ADV_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] bits;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* src/ble_anc_div.sv */
// Bit-serial restoring divider for picosecond-to-tick normalization.
`timescale 1ns / 1ps
`default_nettype none

module ble_anc_div #(
  parameter int unsigned QW = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ble_anc_pkg::div_ctrl_t           ctrl_i,
  input  logic [ble_anc_pkg::DIV_W-1:0]    dvd_i,
  input  logic [ble_anc_pkg::TICK_W-1:0]   dsr_i,
  output ble_anc_pkg::div_stat_t           stat_o,
  output logic [QW-1:0]                    quo_o,
  output logic [ble_anc_pkg::TICK_W-1:0]   rem_o
);
  import ble_anc_pkg::*;

  logic [DIV_W-1:0]     dvd_q;
  logic [TICK_W-1:0]    dsr_q;
  logic [TICK_W-1:0]    rem_q;
  logic [QW-1:0]        quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [TICK_W:0] r2;
  logic [TICK_W:0] diff;
  logic            ge;

  assign r2   = {rem_q, dvd_q[DIV_W-1]};
  assign ge   = (r2 >= {1'b0, dsr_q});
  assign diff = r2 - {1'b0, dsr_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      dvd_q <= dvd_i;
      dsr_q <= dsr_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
      rem_q <= ge ? diff[TICK_W-1:0] : r2[TICK_W-1:0];
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (ctrl_i.start) begin
      cnt_q  <= ctrl_i.bits;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;
  assign rem_o       = rem_q;

endmodule

`default_nettype wire

/* src/ble_conn_anchor_scheduler.sv */
// Connection anchor scheduler: sequencer, link state and result register.
// A start request runs one serial division, an event with packet two (36 and
// 26 steps), a miss one, and a timeout or a terminated link none. One request
// at a time: a new one is taken only once the last result is in the result
// register; the divider is shared by all. Reset is asynchronous, active
// low; it clears all link state and sets the tick period to 30517578 ps.
`timescale 1ns / 1ps
`default_nettype none

module ble_conn_anchor_scheduler #(
  parameter int unsigned COUNTER_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [24:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [23:0] ref_rtc_i,
  input  logic [23:0] first_anchor_off_i,
  input  logic [24:0] offset_rem_ps_i,
  input  logic [13:0] tx_window_us_i,
  input  logic        rx_ok_i,
  input  logic [15:0] sync_to_addr_us_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] anchor_rtc_o,
  output logic [24:0] anchor_rem_ps_o,
  output logic [22:0] rx_extension_us_o,
  output logic [20:0] widening_us_o,
  output logic [15:0] miss_count_o,
  output logic [15:0] max_miss_count_o,
  output logic [31:0] anchor_updates_o,
  output logic        terminated_o
);
  import ble_anc_pkg::*;

  localparam int unsigned CB = COUNTER_BITS;
  localparam int unsigned AW = (CB > 24) ? CB : 24;
  localparam int unsigned EW = (CB > 21) ? CB : 21;

  function automatic logic [20:0] grow(input logic [20:0] w, input logic [15:0] step,
                                       input logic [20:0] limit);
    logic [21:0] s;
    s = {1'b0, w} + {6'b0, step};
    return (s > {1'b0, limit}) ? limit : s[20:0];
  endfunction

  // configuration
  logic [17:0] ival_ticks_q;
  logic [24:0] ival_rem_q;
  logic [24:0] tick_ps_q;
  logic [15:0] wstep_q;
  logic [20:0] wlimit_q;
  logic [20:0] timeout_q;
  logic [7:0]  guard_q;
  logic [9:0]  exp_s2a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ival_ticks_q <= '0;
      ival_rem_q   <= '0;
      tick_ps_q    <= TICK_PS_RESET;
      wstep_q      <= '0;
      wlimit_q     <= '0;
      timeout_q    <= '0;
      guard_q      <= '0;
      exp_s2a_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_INTERVAL_TICKS:  ival_ticks_q <= cfg_wdata_i[17:0];
        CFG_INTERVAL_REM_PS: ival_rem_q   <= cfg_wdata_i;
        CFG_TICK_PERIOD_PS:  tick_ps_q    <= cfg_wdata_i;
        CFG_WIDEN_STEP_US:   wstep_q      <= cfg_wdata_i[15:0];
        CFG_WIDEN_LIMIT_US:  wlimit_q     <= cfg_wdata_i[20:0];
        CFG_TIMEOUT_TICKS:   timeout_q    <= cfg_wdata_i[20:0];
        CFG_GUARD_US:        guard_q      <= cfg_wdata_i[7:0];
        CFG_EXPECTED_S2A_US: exp_s2a_q    <= cfg_wdata_i[9:0];
      endcase
    end
  end

  logic [24:0] tick_eff;
  assign tick_eff = (tick_ps_q == '0) ? 25'd1 : tick_ps_q;

  // request latch
  logic        mode_q;
  logic [23:0] ref_q;
  logic [23:0] off_q;
  logic [24:0] off_rem_q;
  logic [13:0] win_q;
  logic        rx_ok_q;
  logic [15:0] s2a_q;

  // link state
  logic [CB-1:0] anchor_q;
  logic [24:0]   rem_q;
  logic [CB-1:0] last_rx_q;
  logic [20:0]   widen_q;
  logic [13:0]   window_q;
  logic [15:0]   miss_q;
  logic [15:0]   peak_q;
  logic [31:0]   updates_q;
  logic          ended_q;

  // working registers
  logic signed [37:0] prod_q;
  logic [CB-1:0]      base_q;
  logic               neg_q;

  // result register
  logic        out_valid_q;
  logic [23:0] o_anchor_q;
  logic [24:0] o_rem_q;
  logic [22:0] o_ext_q;
  logic [20:0] o_widen_q;
  logic [15:0] o_miss_q;
  logic [15:0] o_peak_q;
  logic [31:0] o_updates_q;
  logic        o_ended_q;

  state_e state_q, state_d;

  div_ctrl_t     div_ctrl;
  div_stat_t     div_stat;
  logic [DIV_W-1:0] div_dvd;
  logic [CB-1:0] div_quo;
  logic [24:0]   div_rem;

  ble_anc_div #(
    .QW(CB)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .dvd_i  (div_dvd),
    .dsr_i  (tick_eff),
    .stat_o (div_stat),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  // datapath helpers
  logic signed [16:0] drift;
  logic signed [37:0] adj;
  logic [37:0]        adj_neg;
  logic [DIV_W-1:0]   adj_mag;
  logic [25:0]        adv_sum;
  logic [15:0]        miss_next;
  logic [CB-1:0]      elapsed;
  logic               timed_out;
  logic               out_free;
  logic [CB-1:0]      drift_anchor;
  logic [24:0]        drift_rem;
  logic               rem_nz;

  assign drift     = $signed({1'b0, s2a_q}) - $signed({7'b0, exp_s2a_q});
  assign adj       = prod_q + $signed({13'b0, rem_q});
  assign adj_neg   = -adj;
  assign adj_mag   = adj[37] ? adj_neg[DIV_W-1:0] : adj[DIV_W-1:0];
  assign adv_sum   = {1'b0, rem_q} + {1'b0, ival_rem_q};
  assign miss_next = (miss_q != 16'hFFFF) ? (miss_q + 16'd1) : miss_q;
  assign elapsed   = anchor_q - last_rx_q;
  assign timed_out = (EW'(elapsed) >= EW'(timeout_q));
  assign out_free  = !out_valid_q || out_ready_i;
  assign rem_nz    = (div_rem != '0);

  always_comb begin
    if (!neg_q) begin
      drift_anchor = anchor_q + div_quo;
      drift_rem    = div_rem;
    end else begin
      drift_anchor = anchor_q - div_quo - CB'(rem_nz);
      drift_rem    = rem_nz ? (tick_eff - div_rem) : '0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:       if (in_valid_i) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        priority if (!mode_q) state_d = ST_START_WAIT;
        else if (ended_q)     state_d = ST_DONE;
        else if (rx_ok_q)     state_d = ST_DRIFT_ADD;
        else if (timed_out)   state_d = ST_DONE;
        else                  state_d = ST_ADV_START;
      end
      ST_START_WAIT: if (div_stat.done) state_d = ST_DONE;
      ST_DRIFT_ADD:  state_d = ST_DRIFT_WAIT;
      ST_DRIFT_WAIT: if (div_stat.done) state_d = ST_ADV_START;
      ST_ADV_START:  state_d = ST_ADV_WAIT;
      ST_ADV_WAIT:   if (div_stat.done) state_d = ST_DONE;
      ST_DONE:       if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o      = 1'b0;
    div_ctrl.start  = 1'b0;
    div_ctrl.bits   = DIV_BITS_START;
    div_dvd         = {off_rem_q, 11'b0};
    unique case (state_q)
      ST_IDLE:     in_ready_o = 1'b1;
      ST_DISPATCH: div_ctrl.start = !mode_q;
      ST_DRIFT_ADD: begin
        div_ctrl.start = 1'b1;
        div_ctrl.bits  = DIV_BITS_DRIFT;
        div_dvd        = adj_mag;
      end
      ST_ADV_START: begin
        div_ctrl.start = 1'b1;
        div_ctrl.bits  = DIV_BITS_ADV;
        div_dvd        = {adv_sum, 10'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request and working registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      mode_q    <= mode_i;
      ref_q     <= ref_rtc_i;
      off_q     <= first_anchor_off_i;
      off_rem_q <= offset_rem_ps_i;
      win_q     <= tx_window_us_i;
      rx_ok_q   <= rx_ok_i;
      s2a_q     <= sync_to_addr_us_i;
    end
    if (state_q == ST_DISPATCH) begin
      base_q <= CB'({1'b0, ref_q} + {1'b0, off_q});
      prod_q <= drift * $signed({1'b0, PS_PER_US});
    end
    if (state_q == ST_DRIFT_ADD) begin
      neg_q <= adj[37];
    end
    if (state_q == ST_ADV_START) begin
      base_q <= anchor_q + CB'(ival_ticks_q);
    end
  end

  // link state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_q  <= '0;
      rem_q     <= '0;
      last_rx_q <= '0;
      widen_q   <= '0;
      window_q  <= '0;
      miss_q    <= '0;
      peak_q    <= '0;
      updates_q <= '0;
      ended_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_DISPATCH: begin
          if (!mode_q) begin
            last_rx_q <= CB'(ref_q);
            window_q  <= win_q;
            miss_q    <= '0;
            peak_q    <= '0;
            updates_q <= '0;
            ended_q   <= 1'b0;
          end else if (!ended_q && !rx_ok_q) begin
            miss_q <= miss_next;
            if (miss_next > peak_q) peak_q <= miss_next;
            if (timed_out) ended_q <= 1'b1;
          end
        end
        ST_START_WAIT: begin
          if (div_stat.done) begin
            anchor_q <= base_q + div_quo;
            rem_q    <= div_rem;
            widen_q  <= grow(21'd0, wstep_q, wlimit_q);
          end
        end
        ST_DRIFT_WAIT: begin
          if (div_stat.done) begin
            anchor_q  <= drift_anchor;
            rem_q     <= drift_rem;
            last_rx_q <= drift_anchor;
            updates_q <= updates_q + 32'd1;
            miss_q    <= '0;
            widen_q   <= '0;
            window_q  <= '0;
          end
        end
        ST_ADV_WAIT: begin
          if (div_stat.done) begin
            anchor_q <= base_q + div_quo;
            rem_q    <= div_rem;
            widen_q  <= grow(widen_q, wstep_q, wlimit_q);
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  logic [AW-1:0] anc_ext;
  logic [21:0]   gw_sum;
  logic [23:0]   ext_sum;

  assign anc_ext = AW'(anchor_q);
  assign gw_sum  = {14'b0, guard_q} + {1'b0, widen_q};
  assign ext_sum = {1'b0, gw_sum, 1'b0} + {10'b0, window_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      o_anchor_q  <= anc_ext[23:0];
      o_rem_q     <= rem_q;
      o_ext_q     <= ext_sum[22:0];
      o_widen_q   <= widen_q;
      o_miss_q    <= miss_q;
      o_peak_q    <= peak_q;
      o_updates_q <= updates_q;
      o_ended_q   <= ended_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign anchor_rtc_o      = o_anchor_q;
  assign anchor_rem_ps_o   = o_rem_q;
  assign rx_extension_us_o = o_ext_q;
  assign widening_us_o     = o_widen_q;
  assign miss_count_o      = o_miss_q;
  assign max_miss_count_o  = o_peak_q;
  assign anchor_updates_o  = o_updates_q;
  assign terminated_o      = o_ended_q;

  a_div_idle_on_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !div_stat.busy)
    else $error("request accepted while divider busy");

  a_div_rem_normalized: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (div_rem < tick_eff))
    else $error("divider remainder not below tick period");

  a_result_posted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> out_valid_o)
    else $error("finished request not posted");

  a_peak_covers_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (peak_q >= miss_q))
    else $error("miss peak below current miss run");

endmodule

`default_nettype wire
